[rtl/aar_pkg.sv]
// Package for the accelerating auto-repeat block.
// Holds the operation and register index codes, field widths, reset values
// of the configuration registers and the item types shared by all modules.
package aar_pkg;

    localparam int OP_W       = 2;
    localparam int POS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DELAY_W    = 16;
    localparam int COUNT_W    = 8;

    localparam int TIMER_WIDTH_DEF = 16;

    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_PRESS   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_EVERY     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL    = 2'd3;

    localparam logic [DELAY_W-1:0] RST_INITIAL_DELAY   = 16'd1000;
    localparam logic [DELAY_W-1:0] RST_REPEAT_INTERVAL = 16'd200;
    localparam logic [COUNT_W-1:0] RST_ACCEL_EVERY     = 8'd10;
    localparam logic [DELAY_W-1:0] RST_MIN_INTERVAL    = 16'd5;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } t_item;

    typedef struct packed {
        logic signed [POS_W-1:0] step_x;
        logic signed [POS_W-1:0] step_y;
    } t_step;

endpackage

[rtl/aar_if.sv]
// Valid/ready channel interfaces for the accelerating auto-repeat block.
// One interface carries input events, the other carries repeat steps.
// Depends on aar_pkg for the field widths.
interface aar_in_if;
    logic                            valid;
    logic                            ready;
    logic [aar_pkg::OP_W-1:0]        op;
    logic signed [aar_pkg::POS_W-1:0] pos_x;
    logic signed [aar_pkg::POS_W-1:0] pos_y;

    modport source (output valid, op, pos_x, pos_y, input ready);
    modport sink (input valid, op, pos_x, pos_y, output ready);
endinterface

interface aar_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [aar_pkg::POS_W-1:0] step_x;
    logic signed [aar_pkg::POS_W-1:0] step_y;

    modport source (output valid, step_x, step_y, input ready);
    modport sink (input valid, step_x, step_y, output ready);
endinterface

[rtl/aar_in_stage.sv]
// Input register of the accelerating auto-repeat block.
// Captures one input transaction and holds it until the core consumes it.
// Depends on aar_pkg and aar_in_if.
module aar_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    aar_in_if.sink          i_in,
    input  logic            i_take,
    output logic            o_vld,
    output aar_pkg::t_item  o_item
);

    logic           r_vld;
    aar_pkg::t_item r_item;
    logic           load;

    assign i_in.ready = !r_vld || i_take;
    assign load       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.op    <= i_in.op;
            r_item.pos_x <= i_in.pos_x;
            r_item.pos_y <= i_in.pos_y;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

[rtl/aar_core.sv]
// Repeat state and configuration registers of the accelerating auto-repeat block.
// Applies one buffered event per cycle unless a due step meets a full output
// register, and produces at most one step. Depends on aar_pkg.
module aar_core #(
    parameter int TIMER_WIDTH = aar_pkg::TIMER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [aar_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [aar_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_vld,
    input  aar_pkg::t_item                  i_item,
    input  logic                            i_out_free,
    output logic                            o_take,
    output logic                            o_res_vld,
    output aar_pkg::t_step                  o_res
);

    localparam int TW = TIMER_WIDTH;
    localparam logic [63:0] TMAX64  = (64'd1 << TW) - 64'd1;
    localparam logic [63:0] RECIP64 = ((64'd1 << (TW + 1)) + 64'd2) / 64'd3;
    localparam logic [TW-1:0] RECIP = RECIP64[TW-1:0];

    logic [aar_pkg::DELAY_W-1:0] r_initial_delay;
    logic [aar_pkg::DELAY_W-1:0] r_repeat_interval;
    logic [aar_pkg::COUNT_W-1:0] r_accel_every;
    logic [aar_pkg::DELAY_W-1:0] r_min_interval;

    logic                         r_held, n_held;
    logic                         r_repeating, n_repeating;
    logic [TW-1:0]                r_countdown, n_countdown;
    logic [TW-1:0]                r_cur, n_cur;
    logic [aar_pkg::COUNT_W-1:0]  r_step_count, n_step_count;
    logic signed [aar_pkg::POS_W-1:0] r_saved_x, n_saved_x;
    logic signed [aar_pkg::POS_W-1:0] r_saved_y, n_saved_y;

    logic [2*TW-1:0]              prod;
    logic [TW-2:0]                third;
    logic [TW-1:0]                rem_full;
    logic [TW-1:0]                shrunk;
    logic [TW-1:0]                shrink_sel;
    logic [aar_pkg::COUNT_W-1:0]  count_inc;
    logic                         fire;

    function automatic logic [TW-1:0] timer_load(input logic [aar_pkg::DELAY_W-1:0] v);
        logic [63:0] v64;
        begin
            v64 = 64'(v);
            if (v64 > TMAX64) begin
                timer_load = TMAX64[TW-1:0];
            end else begin
                timer_load = v64[TW-1:0];
            end
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_delay   <= aar_pkg::RST_INITIAL_DELAY;
            r_repeat_interval <= aar_pkg::RST_REPEAT_INTERVAL;
            r_accel_every     <= aar_pkg::RST_ACCEL_EVERY;
            r_min_interval    <= aar_pkg::RST_MIN_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                aar_pkg::CFG_INITIAL_DELAY: begin
                    r_initial_delay <= i_cfg_data;
                end
                aar_pkg::CFG_REPEAT_INTERVAL: begin
                    r_repeat_interval <= i_cfg_data;
                end
                aar_pkg::CFG_ACCEL_EVERY: begin
                    r_accel_every <= i_cfg_data[aar_pkg::COUNT_W-1:0];
                end
                aar_pkg::CFG_MIN_INTERVAL: begin
                    r_min_interval <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // The shrunk interval is floor(2v/3), built from floor(v/3) by a reciprocal
    // multiply and a correction for a remainder of two.
    assign prod     = (2*TW)'(r_cur) * (2*TW)'(RECIP);
    assign third    = prod[2*TW-1:TW+1];
    assign rem_full = r_cur - ({third, 1'b0} + TW'(third));
    assign shrunk   = {third, 1'b0} + TW'(rem_full[1:0] == 2'd2);

    assign shrink_sel = (32'(r_cur) > 32'(r_min_interval)) ? shrunk : r_cur;
    assign count_inc  = r_step_count + 1'b1;

    assign fire = i_vld && (i_item.op == aar_pkg::OP_TICK) && r_held && r_repeating
                  && (r_countdown <= TW'(1));
    assign o_take    = i_vld && (!fire || i_out_free);
    assign o_res_vld = fire && i_out_free;
    assign o_res.step_x = r_saved_x;
    assign o_res.step_y = r_saved_y;

    always_comb begin
        n_held       = r_held;
        n_repeating  = r_repeating;
        n_countdown  = r_countdown;
        n_cur        = r_cur;
        n_step_count = r_step_count;
        n_saved_x    = r_saved_x;
        n_saved_y    = r_saved_y;
        case (i_item.op)
            aar_pkg::OP_PRESS: begin
                n_held       = 1'b1;
                n_repeating  = 1'b0;
                n_step_count = '0;
                n_saved_x    = i_item.pos_x;
                n_saved_y    = i_item.pos_y;
                n_countdown  = timer_load(r_initial_delay);
            end
            aar_pkg::OP_RELEASE: begin
                n_held       = 1'b0;
                n_repeating  = 1'b0;
                n_countdown  = '0;
                n_step_count = '0;
                n_saved_x    = '0;
                n_saved_y    = '0;
            end
            aar_pkg::OP_TICK: begin
                if (r_held) begin
                    if (r_countdown > TW'(1)) begin
                        n_countdown = r_countdown - TW'(1);
                    end else if (!r_repeating) begin
                        n_repeating = 1'b1;
                        n_cur       = timer_load(r_repeat_interval);
                        n_countdown = timer_load(r_repeat_interval);
                    end else if (count_inc >= r_accel_every) begin
                        n_cur        = shrink_sel;
                        n_countdown  = shrink_sel;
                        n_step_count = '0;
                    end else begin
                        n_step_count = count_inc;
                        n_countdown  = r_cur;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= 1'b0;
            r_repeating  <= 1'b0;
            r_countdown  <= '0;
            r_cur        <= '0;
            r_step_count <= '0;
            r_saved_x    <= '0;
            r_saved_y    <= '0;
        end else if (o_take) begin
            r_held       <= n_held;
            r_repeating  <= n_repeating;
            r_countdown  <= n_countdown;
            r_cur        <= n_cur;
            r_step_count <= n_step_count;
            r_saved_x    <= n_saved_x;
            r_saved_y    <= n_saved_y;
        end
    end

endmodule

[rtl/aar_out_stage.sv]
// Output register of the accelerating auto-repeat block.
// Holds one step transaction until the downstream side takes it.
// Depends on aar_pkg and aar_out_if.
module aar_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  aar_pkg::t_step  i_res,
    output logic            o_free,
    aar_out_if.source       o_step
);

    logic           r_vld;
    aar_pkg::t_step r_res;

    assign o_free = !r_vld || o_step.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (o_step.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_step.valid  = r_vld;
    assign o_step.step_x = r_res.step_x;
    assign o_step.step_y = r_res.step_y;

endmodule

[rtl/accelerating_auto_repeat.sv]
// Accelerating auto-repeat: top level joining input register, core and output register.
// Throughput is one input transaction and one core event per cycle when not stalled.
// A step is valid on the output from the output register, fed by a registered tick.
// Back-pressure on the output stalls the input only when a step is waiting behind it.
// Synchronous active-low reset restores register defaults and a released, idle state.
// Depends on aar_pkg, aar_if, aar_in_stage, aar_core and aar_out_stage.
module accelerating_auto_repeat #(
    parameter int TIMER_WIDTH = aar_pkg::TIMER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [aar_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [aar_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    aar_in_if.sink                          i_in,
    aar_out_if.source                       o_step
);

    logic           item_vld;
    aar_pkg::t_item item;
    logic           take;
    logic           res_vld;
    aar_pkg::t_step res;
    logic           out_free;

    aar_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_vld   (item_vld),
        .o_item  (item)
    );

    aar_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_vld       (item_vld),
        .i_item      (item),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_vld   (res_vld),
        .o_res       (res)
    );

    aar_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_vld),
        .i_res   (res),
        .o_free  (out_free),
        .o_step  (o_step)
    );

endmodule

[tb/sv/accelerating_auto_repeat_test.sv]
// Self-checking testbench for the accelerating auto-repeat block: press, release and tick
// transactions go in through a queue-fed driver, repeat steps are checked by a monitor.
// Depends on aar_pkg, aar_in_if, aar_out_if and accelerating_auto_repeat.
module accelerating_auto_repeat_test;

    localparam logic [aar_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [aar_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [aar_pkg::CFG_DATA_W-1:0] i_cfg_data;

    aar_in_if  ev_if ();
    aar_out_if step_if ();

    accelerating_auto_repeat DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (ev_if),
        .o_step      (step_if)
    );

    // Expected behavior of the block, updated once per accepted input transaction.
    logic [aar_pkg::DELAY_W-1:0] cfg_delay;
    logic [aar_pkg::DELAY_W-1:0] cfg_interval;
    logic [aar_pkg::COUNT_W-1:0] cfg_accel;
    logic [aar_pkg::DELAY_W-1:0] cfg_min;

    logic                        key_held;
    logic                        in_repeat;
    logic [15:0]                 count_left;
    logic [15:0]                 cur_interval;
    logic [aar_pkg::COUNT_W-1:0] steps_since;
    logic [aar_pkg::POS_W-1:0]   held_x;
    logic [aar_pkg::POS_W-1:0]   held_y;

    aar_pkg::t_item queued_events[$];
    aar_pkg::t_step pending_steps[$];

    int send_idle_pct;
    int recv_idle_pct;
    int stall_token;
    int stall_seen;
    int stall_left;
    int errors;
    int n_accepted;
    int n_steps;
    int n_queued;
    int n_settings;

    function automatic void apply_event(aar_pkg::t_item ev);
        logic [16:0] dbl;
        case (ev.op)
            aar_pkg::OP_PRESS: begin
                key_held    = 1'b1;
                in_repeat   = 1'b0;
                steps_since = '0;
                held_x      = ev.pos_x;
                held_y      = ev.pos_y;
                count_left  = cfg_delay;
            end
            aar_pkg::OP_RELEASE: begin
                key_held    = 1'b0;
                in_repeat   = 1'b0;
                count_left  = '0;
                steps_since = '0;
                held_x      = '0;
                held_y      = '0;
            end
            aar_pkg::OP_TICK: begin
                if (key_held) begin
                    if (count_left > 16'd1) begin
                        count_left = count_left - 16'd1;
                    end else if (!in_repeat) begin
                        in_repeat    = 1'b1;
                        cur_interval = cfg_interval;
                        count_left   = cur_interval;
                    end else begin
                        pending_steps.push_back(
                            aar_pkg::t_step'{step_x: held_x, step_y: held_y});
                        steps_since = steps_since + 8'd1;
                        if (steps_since >= cfg_accel) begin
                            if (cur_interval > cfg_min) begin
                                dbl          = {1'b0, cur_interval} << 1;
                                cur_interval = 16'(dbl / 17'd3);
                            end
                            steps_since = '0;
                        end
                        count_left = cur_interval;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        aar_pkg::t_item nxt;
        if (!i_rst_n) begin
            ev_if.valid <= 1'b0;
        end else begin
            if (ev_if.valid && ev_if.ready) begin
                apply_event(aar_pkg::t_item'{op: ev_if.op, pos_x: ev_if.pos_x,
                                             pos_y: ev_if.pos_y});
                n_accepted++;
            end
            if (!ev_if.valid || ev_if.ready) begin
                if (queued_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = queued_events.pop_front();
                    ev_if.valid <= 1'b1;
                    ev_if.op    <= nxt.op;
                    ev_if.pos_x <= nxt.pos_x;
                    ev_if.pos_y <= nxt.pos_y;
                end else begin
                    ev_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            step_if.ready <= 1'b0;
        end else if (stall_token != stall_seen) begin
            stall_seen = stall_token;
            stall_left = 400;
            step_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            step_if.ready <= 1'b0;
        end else begin
            step_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        aar_pkg::t_step want;
        if (i_rst_n && step_if.valid && step_if.ready) begin
            n_steps++;
            if (pending_steps.size() == 0) begin
                $display("%0t: unexpected step: expected none, got x=%0d y=%0d", $time,
                         step_if.step_x, step_if.step_y);
                errors++;
            end else begin
                want = pending_steps.pop_front();
                if (step_if.step_x !== want.step_x) begin
                    $display("%0t: step_x mismatch: expected %0d, got %0d", $time,
                             want.step_x, step_if.step_x);
                    errors++;
                end
                if (step_if.step_y !== want.step_y) begin
                    $display("%0t: step_y mismatch: expected %0d, got %0d", $time,
                             want.step_y, step_if.step_y);
                    errors++;
                end
            end
        end
    end

    function automatic logic [aar_pkg::POS_W-1:0] rand_pos();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_event(logic [aar_pkg::OP_W-1:0] op, logic [aar_pkg::POS_W-1:0] x,
                               logic [aar_pkg::POS_W-1:0] y);
        queued_events.push_back(aar_pkg::t_item'{op: op, pos_x: x, pos_y: y});
        n_queued++;
    endtask

    task automatic queue_ticks(int n);
        repeat (n) queue_event(aar_pkg::OP_TICK, 16'($urandom), 16'($urandom));
    endtask

    task automatic write_reg(logic [aar_pkg::CFG_IDX_W-1:0] idx,
                             logic [aar_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            aar_pkg::CFG_INITIAL_DELAY:   cfg_delay    = val;
            aar_pkg::CFG_REPEAT_INTERVAL: cfg_interval = val;
            aar_pkg::CFG_ACCEL_EVERY:     cfg_accel    = val[aar_pkg::COUNT_W-1:0];
            aar_pkg::CFG_MIN_INTERVAL:    cfg_min      = val;
            default: begin
            end
        endcase
    endtask

    task automatic set_config(int dly, int ivl, int acc, int mn);
        write_reg(aar_pkg::CFG_INITIAL_DELAY, 16'(dly));
        write_reg(aar_pkg::CFG_REPEAT_INTERVAL, 16'(ivl));
        write_reg(aar_pkg::CFG_ACCEL_EVERY, {8'($urandom), 8'(acc)});
        write_reg(aar_pkg::CFG_MIN_INTERVAL, 16'(mn));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (queued_events.size() != 0 || ev_if.valid || pending_steps.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic queue_hold(int span);
        int n;
        int r;
        queue_event(aar_pkg::OP_PRESS, rand_pos(), rand_pos());
        n = $urandom_range(1, span);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 2) begin
                queue_event(OP_UNUSED, 16'($urandom), 16'($urandom));
            end else if (r < 4) begin
                queue_event(aar_pkg::OP_PRESS, rand_pos(), rand_pos());
            end else begin
                queue_ticks(1);
            end
        end
        if ($urandom_range(9) < 8) begin
            queue_event(aar_pkg::OP_RELEASE, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(2))
                0: queue_ticks(1);
                1: queue_event(aar_pkg::OP_RELEASE, 16'($urandom), 16'($urandom));
                default: queue_event(OP_UNUSED, 16'($urandom), 16'($urandom));
            endcase
        end
    endtask

    initial begin
        int p;
        int dly;
        int ivl;
        int acc;
        int mn;
        int span;
        int q0;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        ev_if.valid   = 1'b0;
        ev_if.op      = aar_pkg::OP_TICK;
        ev_if.pos_x   = '0;
        ev_if.pos_y   = '0;
        step_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_token   = 0;
        stall_seen    = 0;
        stall_left    = 0;
        errors        = 0;
        n_accepted    = 0;
        n_steps       = 0;
        n_queued      = 0;
        n_settings    = 0;
        cfg_delay     = aar_pkg::RST_INITIAL_DELAY;
        cfg_interval  = aar_pkg::RST_REPEAT_INTERVAL;
        cfg_accel     = aar_pkg::RST_ACCEL_EVERY;
        cfg_min       = aar_pkg::RST_MIN_INTERVAL;
        key_held      = 1'b0;
        in_repeat     = 1'b0;
        count_left    = '0;
        cur_interval  = '0;
        steps_since   = '0;
        held_x        = '0;
        held_y        = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short directed sequence: idle events, extreme positions, restart, unused op code.
        set_config(2, 3, 2, 1);
        queue_ticks(1);
        queue_event(aar_pkg::OP_RELEASE, 16'h1234, 16'h5678);
        queue_event(OP_UNUSED, 16'hffff, 16'hffff);
        queue_event(aar_pkg::OP_PRESS, 16'h7fff, 16'h8000);
        queue_ticks(6);
        queue_event(aar_pkg::OP_PRESS, 16'h8000, 16'h7fff);
        queue_event(OP_UNUSED, 16'h0000, 16'h0000);
        queue_ticks(5);
        queue_event(aar_pkg::OP_RELEASE, 16'h0000, 16'h0000);
        queue_ticks(1);
        queue_event(aar_pkg::OP_PRESS, 16'h0000, 16'hffff);
        queue_ticks(4);
        queue_event(aar_pkg::OP_RELEASE, 16'hffff, 16'hffff);
        wait_idle();

        for (p = 0; p < 8; p++) begin
            case (p)
                0: begin dly = 1; ivl = 1;   acc = 1;   mn = 0;     end
                1: begin dly = 3; ivl = 4;   acc = 3;   mn = 2;     end
                2: begin dly = 0; ivl = 0;   acc = 0;   mn = 0;     end
                3: begin dly = 5; ivl = 3;   acc = 255; mn = 65535; end
                4: begin dly = 2; ivl = 9;   acc = 2;   mn = 3;     end
                5: begin dly = 1; ivl = 7;   acc = 1;   mn = 1;     end
                6: begin dly = 7; ivl = 2;   acc = 4;   mn = 0;     end
                default: begin dly = 1; ivl = 6; acc = 5; mn = 2;   end
            endcase
            set_config(dly, ivl, acc, mn);
            span = (dly == 0 ? 1 : dly) + 4 * (ivl == 0 ? 1 : ivl) + 4;
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 67; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 67; end
                default: begin send_idle_pct = 26; recv_idle_pct = 26; end
            endcase
            if (p == 0) stall_token++;
            q0 = n_queued;
            do begin
                repeat (3) begin
                    queue_noise();
                    queue_hold(span);
                end
                wait_idle();
            end while (n_queued - q0 < 80);
        end

        repeat (10) @(posedge i_clk);
        $display("Checked %0d repeat steps from %0d input transactions", n_steps, n_accepted);
        $display("over %0d register settings and four idling patterns.", n_settings);
        if (errors == 0 && pending_steps.size() == 0) begin
            $display("accelerating_auto_repeat verification clean");
        end else begin
            $display("accelerating_auto_repeat verification failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("accelerating_auto_repeat verification failed");
        $finish;
    end

endmodule
